### sv/table_charset_codec_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the table charset codec
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TABLE_CHARSET_CODEC_UNIT_DEFINES_SVH
`define TABLE_CHARSET_CODEC_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table charset codec check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table charset codec check failed");

`endif

### sv/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Table charset codec package
// Types, operation codes and constants shared by the codec files.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;

    localparam logic [31:0] UNMAPPED  = 32'hFFFF_FFFF;
    localparam logic [31:0] DOT_CHAR  = 32'h0000_002E;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_DECODE = 2'd1;
    localparam logic [1:0] OP_ENCODE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] entry_index;
        logic [31:0] code_point;
        logic [7:0]  byte_in;
        logic        new_request;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        is_code_point;
        logic        missed;
        logic [31:0] miss_tally;
        logic        last;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

### sv/tcc_cmd_if.sv
// ----------------------------------------------------------------------------
// Codec command channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface tcc_cmd_if
    import tcc_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/tcc_rsp_if.sv
// ----------------------------------------------------------------------------
// Codec result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface tcc_rsp_if
    import tcc_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/table_charset_codec_unit.sv
// A write loads its entry as it transfers; a decode reads its entry at the transfer,
// registers it in the decode state and offers it in the emit state. An encode scans
// one table entry per cycle through the memory read port, from index 0 to the first
// match or the last entry; the unmapped marker ends its scan at once. One command is
// in flight at a time; the next is taken the cycle after the last result. After reset
// the table is swept to all ones, entry by entry, with no commands taken.
// Table charset codec
// Maps byte codes to code points with a table memory: writes load entries, decode
// looks up a single-byte code, encode scans for the lowest matching index.
// ----------------------------------------------------------------------------
`include "table_charset_codec_unit_defines.svh"

module table_charset_codec_unit
    import tcc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    tcc_cmd_if.sink    cmd,
    tcc_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

    // Table memory with a registered read port.
    logic [31:0] map_mem [TABLE_DEPTH];
    logic [31:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [31:0]      miss_cnt_reg;
    logic [31:0]      cp_reg;
    logic [7:0]       lo_byte_reg;
    rsp_item_t        out_reg;

    logic        accept;
    logic        rsp_xfer;
    logic        issue;
    logic        match;
    logic        scan_miss;
    logic        dec_miss;
    logic        miss_inc;
    logic        load_out;
    logic [31:0] miss_cnt_inc;
    logic [15:0] hit16;
    logic        in_range;

    assign accept   = cmd.valid && cmd.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;
    assign in_range = {1'b0, cmd.data.entry_index} < 17'(TABLE_DEPTH);
    assign hit16    = 16'(rd_idx_reg);

    // Scan bookkeeping: a read issued last cycle is compared this cycle.
    assign issue     = (state_reg == ST_SCAN) && (scan_cnt_reg < DEPTH_CNT) && !match;
    assign match     = (state_reg == ST_SCAN) && rd_pend_reg && (rd_data_reg == cp_reg);
    assign scan_miss = (state_reg == ST_SCAN) && !rd_pend_reg && (scan_cnt_reg == DEPTH_CNT);
    assign dec_miss  = (state_reg == ST_DECODE) && (rd_data_reg == UNMAPPED);
    assign miss_inc  = dec_miss || scan_miss;
    assign load_out  = (state_reg == ST_DECODE) || match || scan_miss;
    assign miss_cnt_inc = (miss_cnt_reg == UNMAPPED) ? miss_cnt_reg : miss_cnt_reg + 32'd1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.data.op)
                        OP_DECODE: state_next = ST_DECODE;
                        OP_ENCODE: state_next = ST_SCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DECODE:
            begin
                state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (match || scan_miss)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rsp_xfer && out_reg.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and memory port controls.
    always_comb
    begin
        cmd.ready = (state_reg == ST_IDLE);
        rsp.valid = (state_reg == ST_EMIT);
        rsp.data  = out_reg;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = UNMAPPED;
        mem_re    = 1'b0;
        mem_raddr = scan_cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                mem_waddr = cmd.data.entry_index[IDX_W-1:0];
                mem_wdata = cmd.data.code_point;
                mem_raddr = IDX_W'(cmd.data.byte_in);
                mem_we    = cmd.valid && (cmd.data.op == OP_WRITE) && in_range;
                mem_re    = cmd.valid && (cmd.data.op == OP_DECODE);
            end
            ST_SCAN:
            begin
                mem_re = issue;
            end
            ST_DECODE, ST_EMIT:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            if (accept)
            begin
                if (cmd.data.new_request)
                begin
                    miss_cnt_reg <= '0;
                end
                // The unmapped marker never matches, so its scan ends at once.
                scan_cnt_reg <= (cmd.data.code_point == UNMAPPED) ? DEPTH_CNT : '0;
            end
            else if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (miss_inc)
            begin
                miss_cnt_reg <= miss_cnt_inc;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cp_reg <= cmd.data.code_point;
        end
        if (issue)
        begin
            rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
        if (load_out)
        begin
            out_reg.missed     <= miss_inc;
            out_reg.miss_tally <= miss_inc ? miss_cnt_inc : miss_cnt_reg;
            if (state_reg == ST_DECODE)
            begin
                out_reg.is_code_point <= 1'b1;
                out_reg.last          <= 1'b1;
                out_reg.result_value  <= dec_miss ? DOT_CHAR : rd_data_reg;
            end
            else if (scan_miss)
            begin
                out_reg.is_code_point <= 1'b1;
                out_reg.last          <= 1'b1;
                out_reg.result_value  <= cp_reg;
            end
            else
            begin
                // A hit at 256 or above goes out as a high byte, then a low byte.
                out_reg.is_code_point <= 1'b0;
                lo_byte_reg           <= hit16[7:0];
                if (hit16[15:8] == 8'd0)
                begin
                    out_reg.result_value <= {24'd0, hit16[7:0]};
                    out_reg.last         <= 1'b1;
                end
                else
                begin
                    out_reg.result_value <= {24'd0, hit16[15:8]};
                    out_reg.last         <= 1'b0;
                end
            end
        end
        else if (rsp_xfer && !out_reg.last)
        begin
            out_reg.result_value <= {24'd0, lo_byte_reg};
            out_reg.last         <= 1'b1;
        end
    end

    `TCC_ASSERT_NOW(a_no_cmd_in_clear, state_reg == ST_CLEAR, !cmd.ready && !rsp.valid)
    `TCC_ASSERT_NEXT(a_miss_saturates,
        (miss_cnt_reg == UNMAPPED) && !(accept && cmd.data.new_request),
        miss_cnt_reg == UNMAPPED)
    `TCC_ASSERT_NOW(a_high_byte_is_hit,
        rsp.valid && !rsp.data.last,
        !rsp.data.is_code_point && !rsp.data.missed && (rsp.data.result_value[31:8] == 24'd0))

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Table charset codec testbench
// Drives write, decode, encode and undefined commands into the codec and checks
// every result transfer against a cycle-free model of the mapping table and the
// per-request miss count. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb
    import tcc_pkg::*;
();

    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int STALL_PCT = 24;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int RANDOM_ITEMS = 60;
    localparam int REPORT_MAX = 10;

    typedef struct {
        cmd_item_t item;
        bit        drain;
    } pending_cmd_t;

    logic clk;
    logic rst_n;

    tcc_cmd_if cmd_ch ();
    tcc_rsp_if rsp_ch ();

    table_charset_codec_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    pending_cmd_t cmd_backlog[$];
    rsp_item_t    expected_results[$];

    // Model state: entries never written read as unmapped.
    logic [31:0] code_map[int];
    logic [31:0] miss_total = '0;

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int quiet_cycles;

    function automatic rsp_item_t make_result(logic [31:0] value, logic is_cp, logic miss,
                                              logic final_one);
        rsp_item_t r;
        r.result_value  = value;
        r.is_code_point = is_cp;
        r.missed        = miss;
        r.miss_tally    = miss_total;
        r.last          = final_one;
        return r;
    endfunction

    function automatic void bump_miss_total();
        if (miss_total != UNMAPPED)
            miss_total = miss_total + 32'd1;
    endfunction

    function automatic void predict_codec(cmd_item_t c);
        logic [31:0] entry;
        int          hit;
        bit          found;
        found = 1'b0;
        hit   = 0;
        if (c.new_request)
            miss_total = '0;
        case (c.op)
            OP_WRITE:
            begin
                code_map[int'(c.entry_index)] = c.code_point;
            end
            OP_DECODE:
            begin
                entry = code_map.exists(int'(c.byte_in)) ? code_map[int'(c.byte_in)] : UNMAPPED;
                if (entry == UNMAPPED)
                begin
                    bump_miss_total();
                    expected_results.push_back(make_result(DOT_CHAR, 1'b1, 1'b1, 1'b1));
                end
                else
                begin
                    expected_results.push_back(make_result(entry, 1'b1, 1'b0, 1'b1));
                end
            end
            OP_ENCODE:
            begin
                // The unmapped marker never matches, even where an entry holds it.
                if (c.code_point != UNMAPPED)
                begin
                    foreach (code_map[k])
                    begin
                        if (!found && code_map[k] == c.code_point)
                        begin
                            found = 1'b1;
                            hit   = k;
                        end
                    end
                end
                if (!found)
                begin
                    bump_miss_total();
                    expected_results.push_back(make_result(c.code_point, 1'b1, 1'b1, 1'b1));
                end
                else if (hit < 256)
                begin
                    expected_results.push_back(make_result(32'(hit), 1'b0, 1'b0, 1'b1));
                end
                else
                begin
                    expected_results.push_back(make_result(32'((hit >> 8) & 8'hFF), 1'b0,
                                                           1'b0, 1'b0));
                    expected_results.push_back(make_result(32'(hit & 8'hFF), 1'b0, 1'b0, 1'b1));
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_cmd(logic [1:0] op, logic [15:0] idx, logic [31:0] cp,
                             logic [7:0] b, logic start, bit drain);
        pending_cmd_t p;
        p.item.op          = op;
        p.item.entry_index = idx;
        p.item.code_point  = cp;
        p.item.byte_in     = b;
        p.item.new_request = start;
        p.drain            = drain;
        cmd_backlog.push_back(p);
    endtask

    task automatic note_mismatch(string what, rsp_item_t want, rsp_item_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("mismatch (%s): expected value=%h cp=%b miss=%b count=%h last=%b",
                     what, want.result_value, want.is_code_point, want.missed,
                     want.miss_tally, want.last);
            $display("    got value=%h cp=%b miss=%b count=%h last=%b",
                     got.result_value, got.is_code_point, got.missed, got.miss_tally,
                     got.last);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Command driver; the model is updated at the edge where a transfer happens.
    always @(posedge clk or negedge rst_n)
    begin
        pending_cmd_t next_cmd;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_codec(cmd_ch.data);
                items_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0
                    && ((items_sent >= 45 && items_sent < 75)
                        || $urandom_range(99) >= STALL_PCT)
                    && (!cmd_backlog[0].drain || expected_results.size() == 0))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= next_cmd.item;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.result_value !== want.result_value)
                        note_mismatch("result_value", want, got);
                    else if (got.is_code_point !== want.is_code_point)
                        note_mismatch("is_code_point", want, got);
                    else if (got.missed !== want.missed)
                        note_mismatch("missed", want, got);
                    else if (got.miss_tally !== want.miss_tally)
                        note_mismatch("miss_tally", want, got);
                    else if (got.last !== want.last)
                        note_mismatch("last", want, got);
                end
            end
            rsp_ch.ready <= (results_seen >= 40 && results_seen < 70)
                            || $urandom_range(99) >= STALL_PCT;
        end
    end

    // The limit covers the clearing sweep and a full-table encode scan.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] pool[16];
        logic [31:0] cp;
        logic [15:0] idx;
        logic [1:0]  op;
        int          n;
        int          pick;
        int          slow_budget;

        rst_n = 1'b0;

        // Misses on an empty table, including encode of the unmapped marker.
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'h00, 1'b1, 1'b0);
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'hFF, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, UNMAPPED, 8'h00, 1'b0, 1'b0);
        // An undefined op still honors the start flag.
        queue_cmd(OP_UNDEF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0);
        queue_cmd(OP_WRITE, 16'h0041, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h00FF, 32'h0000_20AC, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'hFFFF, 32'h8000_0001, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h0100, 32'h0001_F600, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'h41, 1'b0, 1'b0);
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'hFF, 1'b0, 1'b0);
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_20AC, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0001_F600, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h8000_0001, 8'h00, 1'b0, 1'b0);
        // Unmap an entry with a write that also starts a new request.
        queue_cmd(OP_WRITE, 16'h0041, UNMAPPED, 8'h00, 1'b1, 1'b0);
        queue_cmd(OP_DECODE, 16'h0000, 32'h0, 8'h41, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h0300, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h0200, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_WRITE, 16'h0010, 32'h0000_0041, 8'h00, 1'b0, 1'b0);
        queue_cmd(OP_ENCODE, 16'h0000, 32'h0000_0041, 8'h00, 1'b0, 1'b0);

        // Pool values parked at indices 1000..1015 keep encode scans short;
        // random writes never touch that range.
        for (int k = 0; k < 16; k++)
        begin
            pool[k] = $urandom;
            if (pool[k] == UNMAPPED)
                pool[k] = 32'hFFFF_FFFE;
            queue_cmd(OP_WRITE, 16'(1000 + k), pool[k], 8'h00, 1'b0, k == 15);
        end

        n           = 0;
        slow_budget = 3;
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            idx  = $urandom;
            cp   = $urandom;
            if (pick < 5)
            begin
                op = OP_UNDEF;
            end
            else if (pick < 30)
            begin
                op  = OP_WRITE;
                idx = $urandom_range(999);
                pick = $urandom_range(9);
                if (pick < 5)
                    cp = pool[$urandom_range(15)];
                else if (pick == 9)
                    cp = UNMAPPED;
                n++;
            end
            else if (pick < 65)
            begin
                op = OP_DECODE;
                n++;
            end
            else
            begin
                op = OP_ENCODE;
                // Few encodes may miss; a miss not on UNMAPPED scans all entries.
                if (slow_budget > 0 && $urandom_range(15) == 0)
                begin
                    slow_budget--;
                    if ($urandom_range(1) == 0)
                        cp = UNMAPPED;
                end
                else
                begin
                    cp = pool[$urandom_range(15)];
                end
                n++;
            end
            queue_cmd(op, idx, cp, 8'($urandom), $urandom_range(7) == 0, n == 50);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
